// ----- hdl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared forms for concurrent assertions on a clock named clock.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while reset is low.
`define ERH_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define ERH_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ----- hdl/erh_pkg.sv -----
// ----------------------------------------------------------------------------
// erh_pkg
// Widths, operation codes and result kinds of the ensemble rank histogram.
// ----------------------------------------------------------------------------
package erh_pkg;

   localparam int MAX_MEMBERS = 64;
   localparam int NBINS       = MAX_MEMBERS + 1;
   localparam int VALUE_W     = 32;
   localparam int COUNT_W     = 32;
   localparam int CNT_W       = 7;
   localparam int BIN_W       = 7;
   localparam int RAND_W      = 16;
   localparam int OP_W        = 2;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;

   // Operation codes of a request.
   localparam logic [OP_W-1:0] OP_SAMPLE = 2'd0;
   localparam logic [OP_W-1:0] OP_READ   = 2'd1;
   localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;
   localparam logic [OP_W-1:0] OP_NONE   = 2'd3;

   // Result kinds.
   localparam logic KIND_RANK = 1'b0;
   localparam logic KIND_READ = 1'b1;

   // Register index of ensemble_size (address bit 2 selects the register).
   localparam logic REG_ENSEMBLE_SIZE = 1'b0;

   localparam logic [CNT_W-1:0]   CNT_MAX   = {CNT_W{1'b1}};
   localparam logic [COUNT_W-1:0] BIN_MAX   = {COUNT_W{1'b1}};
   localparam logic [BIN_W-1:0]   LAST_BIN  = BIN_W'(NBINS - 1);
   localparam logic [CNT_W-1:0]   MEMBERS_LIMIT = CNT_W'(MAX_MEMBERS);

   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
      return (c == CNT_MAX) ? c : c + 1'b1;
   endfunction

endpackage

// ----- hdl/ensemble_rank_histogram.sv -----
// Pipeline: a request accepted into stage 1 moves to stage 2, then to the response registers.
// Throughput: one request per cycle unless a stalled response holds the pipeline; the
// histogram RAM is read one stage ahead of the write-back, and a write at the same edge
// as a read of the same bin is forwarded.
// Reset (synchronous): counters zero, ensemble_size one, all bins read as zero at once
// through per-bin valid flags; a clear request empties the histogram the same way.
// ----------------------------------------------------------------------------
// ensemble_rank_histogram
// Counts members below and tied with the observation, forms the rank on the
// last member and accumulates it in a 65-bin saturating histogram kept in RAM.
// ----------------------------------------------------------------------------
module ensemble_rank_histogram (
   input  logic                                  clock,
   input  logic                                  reset,
   // Request channel
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [erh_pkg::OP_W-1:0]              req_operation,
   input  logic signed [erh_pkg::VALUE_W-1:0]    req_observation,
   input  logic signed [erh_pkg::VALUE_W-1:0]    req_member_value,
   input  logic                                  req_member_valid,
   input  logic                                  req_last_member,
   input  logic [erh_pkg::RAND_W-1:0]            req_tie_random,
   input  logic [erh_pkg::BIN_W-1:0]             req_bin_index,
   // Response channel
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic                                  rsp_result_kind,
   output logic [erh_pkg::BIN_W-1:0]             rsp_rank,
   output logic                                  rsp_rank_valid,
   output logic [erh_pkg::CNT_W-1:0]             rsp_valid_members,
   output logic [erh_pkg::COUNT_W-1:0]           rsp_bin_count,
   // Register port
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [erh_pkg::CSR_ADDR_W-1:0]        csr_paddr,
   input  logic [erh_pkg::CSR_DATA_W-1:0]        csr_pwdata,
   output logic [erh_pkg::CSR_DATA_W-1:0]        csr_prdata,
   output logic                                  csr_pready
);

   // ---------------- register port ----------------
   logic [erh_pkg::CNT_W-1:0] ens_size_ff, ens_size_in;
   logic                      csr_sel_size;

   assign csr_pready   = 1'b1;
   assign csr_sel_size = (csr_paddr[2] == erh_pkg::REG_ENSEMBLE_SIZE);

   always_comb begin
      ens_size_in = ens_size_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_sel_size) begin
         ens_size_in = csr_pwdata[erh_pkg::CNT_W-1:0];
      end
   end

   assign csr_prdata = csr_sel_size ?
      {{(erh_pkg::CSR_DATA_W-erh_pkg::CNT_W){1'b0}}, ens_size_ff} : '0;

   // ---------------- pipeline control ----------------
   logic s1_valid_ff, s1_valid_in;
   logic s2_valid_ff, s2_valid_in;
   logic out_valid_ff, out_valid_in;
   logic s1_go, s2_go, req_fire, out_load;
   logic s2_has_rsp_ff;

   assign s2_go     = s2_valid_ff && (!s2_has_rsp_ff || !out_valid_ff || rsp_ready);
   assign s1_go     = s1_valid_ff && (!s2_valid_ff || s2_go);
   assign req_ready = !s1_valid_ff || s1_go;
   assign req_fire  = req_valid && req_ready;
   assign out_load  = s2_go && s2_has_rsp_ff;

   assign s1_valid_in  = req_fire || (s1_valid_ff && !s1_go);
   assign s2_valid_in  = s1_go || (s2_valid_ff && !s2_go);
   assign out_valid_in = out_load || (out_valid_ff && !rsp_ready);

   // ---------------- stage 0: member counters ----------------
   logic [erh_pkg::CNT_W-1:0] below_ff, below_in, tie_ff, tie_in, vcnt_ff, vcnt_in;
   logic [erh_pkg::CNT_W-1:0] below_nx, tie_nx, vcnt_nx;
   logic                      is_sample;

   assign is_sample = (req_operation == erh_pkg::OP_SAMPLE);

   always_comb begin
      below_nx = below_ff;
      tie_nx   = tie_ff;
      vcnt_nx  = vcnt_ff;
      if (req_member_valid) begin
         vcnt_nx = erh_pkg::sat_inc(vcnt_ff);
         if (req_member_value == req_observation) begin
            tie_nx = erh_pkg::sat_inc(tie_ff);
         end else if (req_member_value < req_observation) begin
            below_nx = erh_pkg::sat_inc(below_ff);
         end
      end
   end

   always_comb begin
      below_in = below_ff;
      tie_in   = tie_ff;
      vcnt_in  = vcnt_ff;
      if (req_fire && is_sample) begin
         if (req_last_member) begin
            below_in = '0;
            tie_in   = '0;
            vcnt_in  = '0;
         end else begin
            below_in = below_nx;
            tie_in   = tie_nx;
            vcnt_in  = vcnt_nx;
         end
      end
   end

   // ---------------- stage 1: rank and RAM read ----------------
   logic [erh_pkg::OP_W-1:0]   s1_op_ff;
   logic                       s1_last_ff;
   logic [erh_pkg::CNT_W-1:0]  s1_below_ff, s1_tie_ff, s1_vcnt_ff;
   logic [erh_pkg::RAND_W-1:0] s1_rand_ff;
   logic [erh_pkg::BIN_W-1:0]  s1_bin_ff;

   logic [erh_pkg::RAND_W+erh_pkg::CNT_W:0] s1_prod;
   logic [erh_pkg::CNT_W:0]                 s1_rank_m1, s1_rank;
   logic                                    s1_ok, s1_bin_in_range;
   logic                                    s1_has_rsp, s1_wr, s1_clear, s1_kind;
   logic [erh_pkg::BIN_W-1:0]               s1_addr;

   assign s1_prod = s1_rand_ff * ({1'b0, s1_tie_ff} + 1'b1);
   assign s1_rank_m1 = {1'b0, s1_below_ff} +
      s1_prod[erh_pkg::RAND_W +: (erh_pkg::CNT_W+1)];
   assign s1_rank = s1_rank_m1 + 1'b1;
   assign s1_ok = (s1_vcnt_ff == ens_size_ff) && (s1_vcnt_ff <= erh_pkg::MEMBERS_LIMIT);
   assign s1_bin_in_range = (s1_bin_ff <= erh_pkg::LAST_BIN);

   always_comb begin
      s1_has_rsp = 1'b0;
      s1_wr      = 1'b0;
      s1_clear   = 1'b0;
      s1_kind    = erh_pkg::KIND_RANK;
      s1_addr    = '0;
      unique case (s1_op_ff)
         erh_pkg::OP_SAMPLE: begin
            s1_has_rsp = s1_last_ff;
            s1_wr      = s1_last_ff && s1_ok;
            // Out of range only when no rank is formed; the address is unused then.
            s1_addr    = s1_ok ? s1_rank_m1[erh_pkg::BIN_W-1:0] : '0;
         end
         erh_pkg::OP_READ: begin
            s1_has_rsp = 1'b1;
            s1_kind    = erh_pkg::KIND_READ;
            s1_addr    = s1_bin_in_range ? s1_bin_ff : '0;
         end
         erh_pkg::OP_CLEAR: begin
            s1_clear = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // ---------------- histogram RAM ----------------
   logic [erh_pkg::COUNT_W-1:0] hist_mem_ff [erh_pkg::NBINS];
   logic [erh_pkg::COUNT_W-1:0] rd_data_ff;
   logic [erh_pkg::NBINS-1:0]   bin_valid_ff, bin_valid_in;

   // ---------------- stage 2: modify and write back ----------------
   logic                        s2_wr_ff, s2_clear_ff, s2_kind_ff, s2_in_range_ff;
   logic [erh_pkg::BIN_W-1:0]   s2_addr_ff;
   logic [erh_pkg::BIN_W-1:0]   s2_rank_ff;
   logic [erh_pkg::CNT_W-1:0]   s2_vcnt_ff;
   logic                        fwd_hit_ff;
   logic [erh_pkg::COUNT_W-1:0] fwd_data_ff;
   logic [erh_pkg::COUNT_W-1:0] s2_cur, s2_new, s2_count;
   logic                        s2_write;

   assign s2_write = s2_go && s2_wr_ff;

   always_comb begin
      if (!bin_valid_ff[s2_addr_ff]) begin
         s2_cur = '0;
      end else if (fwd_hit_ff) begin
         s2_cur = fwd_data_ff;
      end else begin
         s2_cur = rd_data_ff;
      end
   end

   assign s2_new = (s2_cur == erh_pkg::BIN_MAX) ? s2_cur : s2_cur + 1'b1;

   always_comb begin
      priority if (s2_wr_ff) begin
         s2_count = s2_new;
      end else if (s2_kind_ff == erh_pkg::KIND_READ && s2_in_range_ff) begin
         s2_count = s2_cur;
      end else begin
         s2_count = '0;
      end
   end

   always_comb begin
      bin_valid_in = bin_valid_ff;
      if (s2_go && s2_clear_ff) begin
         bin_valid_in = '0;
      end else if (s2_write) begin
         bin_valid_in[s2_addr_ff] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_write) begin
         hist_mem_ff[s2_addr_ff] <= s2_new;
      end
      if (s1_go) begin
         rd_data_ff <= hist_mem_ff[s1_addr];
      end
   end

   // ---------------- control registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         ens_size_ff  <= erh_pkg::CNT_W'(1);
         below_ff     <= '0;
         tie_ff       <= '0;
         vcnt_ff      <= '0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         bin_valid_ff <= '0;
      end else begin
         ens_size_ff  <= ens_size_in;
         below_ff     <= below_in;
         tie_ff       <= tie_in;
         vcnt_ff      <= vcnt_in;
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         out_valid_ff <= out_valid_in;
         bin_valid_ff <= bin_valid_in;
      end
   end

   // ---------------- payload registers ----------------
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_op_ff    <= req_operation;
         s1_last_ff  <= req_last_member;
         s1_below_ff <= below_nx;
         s1_tie_ff   <= tie_nx;
         s1_vcnt_ff  <= vcnt_nx;
         s1_rand_ff  <= req_tie_random;
         s1_bin_ff   <= req_bin_index;
      end
      if (s1_go) begin
         s2_has_rsp_ff  <= s1_has_rsp;
         s2_wr_ff       <= s1_wr;
         s2_clear_ff    <= s1_clear;
         s2_kind_ff     <= s1_kind;
         s2_in_range_ff <= s1_bin_in_range;
         s2_addr_ff     <= s1_addr;
         s2_rank_ff     <= s1_wr ? s1_rank[erh_pkg::BIN_W-1:0] : '0;
         s2_vcnt_ff     <= (s1_kind == erh_pkg::KIND_READ) ? '0 : s1_vcnt_ff;
         // The write leaving stage 2 at this edge is missed by the RAM read.
         fwd_hit_ff     <= s2_write && (s2_addr_ff == s1_addr);
         fwd_data_ff    <= s2_new;
      end
      if (out_load) begin
         rsp_result_kind   <= s2_kind_ff;
         rsp_rank          <= s2_rank_ff;
         rsp_rank_valid    <= s2_wr_ff;
         rsp_valid_members <= s2_vcnt_ff;
         rsp_bin_count     <= s2_count;
      end
   end

   assign rsp_valid = out_valid_ff;

endmodule

// ----- hdl/erh_checker.sv -----
// ----------------------------------------------------------------------------
// erh_checker
// Port-level checks of the ensemble rank histogram response channel.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module erh_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic                          rsp_result_kind,
   input logic [erh_pkg::BIN_W-1:0]     rsp_rank,
   input logic                          rsp_rank_valid,
   input logic [erh_pkg::CNT_W-1:0]     rsp_valid_members,
   input logic [erh_pkg::COUNT_W-1:0]   rsp_bin_count
);

   // A stalled response keeps its payload.
   `ERH_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_bin_count) && $stable(rsp_rank), "response changed while stalled")

   `ERH_ASSERT_ALWAYS(a_reset_idle, reset |=> !rsp_valid, "response valid right after reset")

   `ERH_ASSERT(a_read_fields, rsp_valid && rsp_result_kind == erh_pkg::KIND_READ |-> rsp_rank == '0 && !rsp_rank_valid && rsp_valid_members == '0, "bin read carries rank fields")

   // A formed rank has just incremented its bin, so the count is never zero.
   `ERH_ASSERT(a_rank_formed, rsp_valid && rsp_result_kind == erh_pkg::KIND_RANK && rsp_rank_valid |-> rsp_rank != '0 && rsp_bin_count != '0, "formed rank with zero rank or count")

   `ERH_ASSERT(a_rank_missing, rsp_valid && rsp_result_kind == erh_pkg::KIND_RANK && !rsp_rank_valid |-> rsp_rank == '0 && rsp_bin_count == '0, "missing rank with nonzero fields")

endmodule

bind ensemble_rank_histogram erh_checker u_erh_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_result_kind   (rsp_result_kind),
   .rsp_rank          (rsp_rank),
   .rsp_rank_valid    (rsp_rank_valid),
   .rsp_valid_members (rsp_valid_members),
   .rsp_bin_count     (rsp_bin_count)
);

// ----- tb/sv/ensemble_rank_histogram_tb.sv -----
// ----------------------------------------------------------------------------
// ensemble_rank_histogram_tb
// Self-checking bench for the rank histogram. Member, read and clear requests
// go in with random gaps while responses are taken with random stalls. Each
// accepted request updates a local copy of the counters and the bins, and
// every response is compared field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module ensemble_rank_histogram_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT   = 500000;
   localparam int SETTLE_CYCLES = 8;
   localparam int RANDOM_ITEMS  = 1200;

   localparam logic [erh_pkg::CSR_ADDR_W-1:0] SIZE_ADDR = {erh_pkg::REG_ENSEMBLE_SIZE, 2'b00};

   typedef enum int { MEMBER_TIE, MEMBER_BELOW, MEMBER_ABOVE, MEMBER_ANY } member_mode_type;

   typedef struct {
      logic [erh_pkg::OP_W-1:0]           operation;
      logic signed [erh_pkg::VALUE_W-1:0] observation;
      logic signed [erh_pkg::VALUE_W-1:0] member_value;
      logic                               member_valid;
      logic                               last_member;
      logic [erh_pkg::RAND_W-1:0]         tie_random;
      logic [erh_pkg::BIN_W-1:0]          bin_index;
   } request_type;

   typedef struct {
      logic                        kind;
      logic [erh_pkg::BIN_W-1:0]   rank;
      logic                        rank_valid;
      logic [erh_pkg::CNT_W-1:0]   members;
      logic [erh_pkg::COUNT_W-1:0] count;
   } result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                               req_valid = 1'b0;
   logic                               req_ready;
   logic [erh_pkg::OP_W-1:0]           req_operation = erh_pkg::OP_NONE;
   logic signed [erh_pkg::VALUE_W-1:0] req_observation = '0;
   logic signed [erh_pkg::VALUE_W-1:0] req_member_value = '0;
   logic                               req_member_valid = 1'b0;
   logic                               req_last_member = 1'b0;
   logic [erh_pkg::RAND_W-1:0]         req_tie_random = '0;
   logic [erh_pkg::BIN_W-1:0]          req_bin_index = '0;

   logic                               rsp_valid;
   logic                               rsp_ready = 1'b0;
   logic                               rsp_result_kind;
   logic [erh_pkg::BIN_W-1:0]          rsp_rank;
   logic                               rsp_rank_valid;
   logic [erh_pkg::CNT_W-1:0]          rsp_valid_members;
   logic [erh_pkg::COUNT_W-1:0]        rsp_bin_count;

   logic                               csr_psel = 1'b0;
   logic                               csr_penable = 1'b0;
   logic                               csr_pwrite = 1'b0;
   logic [erh_pkg::CSR_ADDR_W-1:0]     csr_paddr = '0;
   logic [erh_pkg::CSR_DATA_W-1:0]     csr_pwdata = '0;
   logic [erh_pkg::CSR_DATA_W-1:0]     csr_prdata;
   logic                               csr_pready;

   // Local copy of the block's state.
   logic [erh_pkg::CNT_W-1:0]   size_setting = erh_pkg::CNT_W'(1);
   logic [erh_pkg::CNT_W-1:0]   below_seen = '0;
   logic [erh_pkg::CNT_W-1:0]   ties_seen = '0;
   logic [erh_pkg::CNT_W-1:0]   members_seen = '0;
   logic [erh_pkg::COUNT_W-1:0] bin_counts [erh_pkg::NBINS];

   result_type  pending_results [$];
   int unsigned error_count = 0;
   int unsigned requests_sent = 0;
   int unsigned responses_checked = 0;
   int unsigned ranks_formed = 0;
   int unsigned cycle_count = 0;
   int          ready_hold = 0;
   bit          steady_flow = 1'b0;

   ensemble_rank_histogram uut (.*);

   initial begin
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d responses outstanding",
                  cycle_count, pending_results.size());
         $display("Some tests failed");
         $finish;
      end
   end

   function automatic int idle_cycles();
      return steady_flow ? 0 : $urandom_range(0, 9);
   endfunction

   // Advances the local state by one accepted request and queues the response it causes.
   function automatic void predict_histogram(input request_type r);
      result_type  res;
      int unsigned rk;
      res = '{erh_pkg::KIND_RANK, '0, 1'b0, '0, '0};
      case (r.operation)
         erh_pkg::OP_SAMPLE: begin
            if (r.member_valid) begin
               if (members_seen != {erh_pkg::CNT_W{1'b1}}) members_seen++;
               if (r.member_value == r.observation) begin
                  if (ties_seen != {erh_pkg::CNT_W{1'b1}}) ties_seen++;
               end else if (r.member_value < r.observation) begin
                  if (below_seen != {erh_pkg::CNT_W{1'b1}}) below_seen++;
               end
            end
            if (r.last_member) begin
               res.members = members_seen;
               if (members_seen == size_setting && members_seen <= erh_pkg::MAX_MEMBERS) begin
                  // Ties spread the rank evenly over below+1 .. below+ties+1.
                  rk = below_seen + 1 + ((int'(r.tie_random) * (int'(ties_seen) + 1)) >> 16);
                  if (bin_counts[rk-1] != {erh_pkg::COUNT_W{1'b1}}) bin_counts[rk-1]++;
                  res.rank       = erh_pkg::BIN_W'(rk);
                  res.rank_valid = 1'b1;
                  res.count      = bin_counts[rk-1];
                  ranks_formed++;
               end
               pending_results = {pending_results, res};
               below_seen   = '0;
               ties_seen    = '0;
               members_seen = '0;
            end
         end
         erh_pkg::OP_READ: begin
            res.kind  = erh_pkg::KIND_READ;
            res.count = (r.bin_index < erh_pkg::NBINS) ? bin_counts[r.bin_index] : '0;
            pending_results = {pending_results, res};
         end
         erh_pkg::OP_CLEAR: begin
            foreach (bin_counts[i]) bin_counts[i] = '0;
         end
         default: ;
      endcase
   endfunction

   // Response side: random stalls on ready, and every accepted response is checked.
   always @(posedge clock) begin : response_side
      int         w;
      result_type exp;
      if (reset) begin
         rsp_ready  <= 1'b0;
         ready_hold <= idle_cycles();
      end else if (rsp_ready) begin
         if (rsp_valid) begin
            responses_checked++;
            if (pending_results.size() == 0) begin
               $error("response arrived with nothing pending: kind %0d bin_count %0d",
                      rsp_result_kind, rsp_bin_count);
               error_count++;
            end else begin
               exp = pending_results.pop_front();
               if (rsp_result_kind !== exp.kind) begin
                  $error("result_kind: expected %0d, got %0d", exp.kind, rsp_result_kind);
                  error_count++;
               end
               if (rsp_rank !== exp.rank) begin
                  $error("rank: expected %0d, got %0d", exp.rank, rsp_rank);
                  error_count++;
               end
               if (rsp_rank_valid !== exp.rank_valid) begin
                  $error("rank_valid: expected %0d, got %0d", exp.rank_valid, rsp_rank_valid);
                  error_count++;
               end
               if (rsp_valid_members !== exp.members) begin
                  $error("valid_members: expected %0d, got %0d",
                         exp.members, rsp_valid_members);
                  error_count++;
               end
               if (rsp_bin_count !== exp.count) begin
                  $error("bin_count: expected %0d, got %0d", exp.count, rsp_bin_count);
                  error_count++;
               end
            end
            w = idle_cycles();
            if (w != 0) begin
               rsp_ready  <= 1'b0;
               ready_hold <= w;
            end
         end
      end else if (ready_hold > 1) begin
         ready_hold <= ready_hold - 1;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Sends one request. Valid stays high on return so a back-to-back request
   // can follow; anything that waits instead must lower it first.
   task automatic send_request(input request_type r);
      int gap;
      gap = idle_cycles();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_operation    <= r.operation;
      req_observation  <= r.observation;
      req_member_value <= r.member_value;
      req_member_valid <= r.member_valid;
      req_last_member  <= r.last_member;
      req_tie_random   <= r.tie_random;
      req_bin_index    <= r.bin_index;
      do @(posedge clock); while (!req_ready);
      predict_histogram(r);
      if (r.operation != erh_pkg::OP_NONE) requests_sent++;
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_ensemble_size(input logic [erh_pkg::CNT_W-1:0] members);
      wait_idle();
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= SIZE_ADDR;
      csr_pwdata  <= erh_pkg::CSR_DATA_W'(members);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      size_setting = members;
   endtask

   function automatic logic signed [erh_pkg::VALUE_W-1:0] pick_value();
      case ($urandom_range(0, 5))
         0:       return {1'b1, {(erh_pkg::VALUE_W-1){1'b0}}};
         1:       return {1'b0, {(erh_pkg::VALUE_W-1){1'b1}}};
         2:       return '0;
         3:       return '1;
         default: return erh_pkg::VALUE_W'($urandom);
      endcase
   endfunction

   // Every field random, so the fields a given operation ignores still toggle.
   function automatic request_type random_request();
      request_type r;
      r.operation    = erh_pkg::OP_W'($urandom_range(0, 3));
      r.observation  = erh_pkg::VALUE_W'($urandom);
      r.member_value = erh_pkg::VALUE_W'($urandom);
      r.member_valid = 1'($urandom);
      r.last_member  = 1'($urandom);
      r.tie_random   = erh_pkg::RAND_W'($urandom);
      r.bin_index    = erh_pkg::BIN_W'($urandom);
      return r;
   endfunction

   function automatic request_type member_request(
         input logic signed [erh_pkg::VALUE_W-1:0] obs,
         input logic signed [erh_pkg::VALUE_W-1:0] value,
         input logic present, input logic last,
         input logic [erh_pkg::RAND_W-1:0] rnd);
      request_type r;
      r              = random_request();
      r.operation    = erh_pkg::OP_SAMPLE;
      r.observation  = obs;
      r.member_value = value;
      r.member_valid = present;
      r.last_member  = last;
      r.tie_random   = rnd;
      return r;
   endfunction

   function automatic request_type op_request(input logic [erh_pkg::OP_W-1:0] op,
                                              input logic [erh_pkg::BIN_W-1:0] bin);
      request_type r;
      r           = random_request();
      r.operation = op;
      r.bin_index = bin;
      return r;
   endfunction

   function automatic logic signed [erh_pkg::VALUE_W-1:0] member_near(
         input logic signed [erh_pkg::VALUE_W-1:0] obs, input member_mode_type mode);
      case (mode)
         MEMBER_TIE:   return obs;
         MEMBER_BELOW: return (obs == {1'b1, {(erh_pkg::VALUE_W-1){1'b0}}}) ? obs + 1 :
                              obs - erh_pkg::VALUE_W'($urandom_range(1, 1000));
         MEMBER_ABOVE: return (obs == {1'b0, {(erh_pkg::VALUE_W-1){1'b1}}}) ? obs - 1 :
                              obs + erh_pkg::VALUE_W'($urandom_range(1, 1000));
         default:      return pick_value();
      endcase
   endfunction

   // A full ensemble of valid members of one kind against a fixed observation.
   task automatic send_members(input int count, input member_mode_type mode,
                               input logic [erh_pkg::RAND_W-1:0] rnd);
      logic signed [erh_pkg::VALUE_W-1:0] obs;
      logic signed [erh_pkg::VALUE_W-1:0] value;
      obs = (mode == MEMBER_BELOW) ? {1'b0, {(erh_pkg::VALUE_W-1){1'b1}}} :
            (mode == MEMBER_ABOVE) ? {1'b1, {(erh_pkg::VALUE_W-1){1'b0}}} : pick_value();
      for (int i = 0; i < count; i++) begin
         value = (mode == MEMBER_TIE) ? obs : member_near(obs, mode);
         send_request(member_request(obs, value, 1'b1, i == count - 1, rnd));
      end
   endtask

   task automatic test_single_member();
      logic signed [erh_pkg::VALUE_W-1:0] lo;
      logic signed [erh_pkg::VALUE_W-1:0] hi;
      lo = {1'b1, {(erh_pkg::VALUE_W-1){1'b0}}};
      hi = {1'b0, {(erh_pkg::VALUE_W-1){1'b1}}};
      // Reset leaves the ensemble size at one.
      send_request(member_request(hi, lo, 1'b1, 1'b1, 16'h0000));
      send_request(member_request(lo, hi, 1'b1, 1'b1, 16'hFFFF));
      send_request(member_request('0, '0, 1'b1, 1'b1, 16'h0000));
      send_request(member_request('0, '0, 1'b1, 1'b1, 16'hFFFF));
      send_request(member_request('1, '1, 1'b1, 1'b1, 16'h8000));
      send_request(member_request(hi, hi, 1'b1, 1'b1, 16'h7FFF));
      send_request(member_request(lo, lo, 1'b0, 1'b1, 16'hFFFF));
      send_request(op_request(erh_pkg::OP_NONE, '0));
      send_request(member_request(lo, hi, 1'b0, 1'b0, 16'h1234));
      send_request(member_request(lo, lo, 1'b1, 1'b1, 16'hFFFF));
      send_request(op_request(erh_pkg::OP_READ, erh_pkg::BIN_W'(0)));
      send_request(op_request(erh_pkg::OP_READ, erh_pkg::BIN_W'(1)));
      send_request(op_request(erh_pkg::OP_READ, erh_pkg::LAST_BIN));
      send_request(op_request(erh_pkg::OP_READ, erh_pkg::BIN_W'(erh_pkg::NBINS)));
      send_request(op_request(erh_pkg::OP_READ, {erh_pkg::BIN_W{1'b1}}));
      send_request(op_request(erh_pkg::OP_CLEAR, '0));
      send_request(op_request(erh_pkg::OP_READ, erh_pkg::BIN_W'(0)));
      send_request(op_request(erh_pkg::OP_READ, erh_pkg::BIN_W'(1)));
   endtask

   task automatic test_size_extremes();
      // With a size of zero only an ensemble without valid members ranks, at rank one.
      write_ensemble_size('0);
      send_request(member_request('0, '0, 1'b0, 1'b1, 16'hFFFF));
      send_request(member_request('0, '0, 1'b0, 1'b0, 16'h0000));
      send_request(member_request('0, '1, 1'b0, 1'b1, 16'h0000));
      send_request(member_request('0, '0, 1'b1, 1'b1, 16'h0000));
      write_ensemble_size(erh_pkg::MEMBERS_LIMIT);
      send_members(erh_pkg::MAX_MEMBERS, MEMBER_TIE, 16'hFFFF);
      send_members(erh_pkg::MAX_MEMBERS, MEMBER_TIE, 16'h0000);
      send_members(erh_pkg::MAX_MEMBERS, MEMBER_BELOW, 16'h5555);
      send_members(erh_pkg::MAX_MEMBERS, MEMBER_ABOVE, 16'hAAAA);
      send_members(erh_pkg::MAX_MEMBERS, MEMBER_ANY, 16'h8000);
      send_members(erh_pkg::MAX_MEMBERS + 1, MEMBER_ANY, 16'h0001);
      send_request(op_request(erh_pkg::OP_READ, erh_pkg::LAST_BIN));
      // A size above the bin count can never rank, and the counters stop at their top.
      write_ensemble_size({erh_pkg::CNT_W{1'b1}});
      send_members(130, MEMBER_BELOW, 16'hFFFF);
      send_members(127, MEMBER_TIE, 16'hFFFF);
   endtask

   task automatic test_clear_keeps_counters();
      write_ensemble_size(erh_pkg::CNT_W'(3));
      send_request(member_request('0, '1, 1'b1, 1'b0, '0));
      send_request(member_request('0, '0, 1'b1, 1'b0, '0));
      send_request(op_request(erh_pkg::OP_CLEAR, '0));
      send_request(op_request(erh_pkg::OP_READ, erh_pkg::BIN_W'(1)));
      send_request(member_request('0, '0, 1'b1, 1'b1, 16'hFFFF));
      send_request(op_request(erh_pkg::OP_READ, erh_pkg::BIN_W'(3)));
   endtask

   // Mostly well-formed ensembles with random content; now and then a member
   // goes missing, the ensemble runs long or short, or a read, clear or idle
   // operation lands in the middle of it.
   task automatic send_random_ensemble(input int members);
      int                                 count;
      logic signed [erh_pkg::VALUE_W-1:0] obs;
      logic signed [erh_pkg::VALUE_W-1:0] cur_obs;
      request_type                        r;
      count = members;
      case ($urandom_range(0, 11))
         0:       count = members + $urandom_range(1, 3);
         1:       count = (members > 1) ? members - 1 : members;
         default: ;
      endcase
      obs = pick_value();
      for (int i = 0; i < count; i++) begin
         case ($urandom_range(0, 59))
            0, 1, 2: send_request(op_request(erh_pkg::OP_READ,
                        erh_pkg::BIN_W'($urandom_range(0, erh_pkg::NBINS - 1))));
            3:       send_request(op_request(erh_pkg::OP_NONE, '0));
            default: ;
         endcase
         if ($urandom_range(0, 299) == 0) send_request(op_request(erh_pkg::OP_CLEAR, '0));
         cur_obs = ($urandom_range(0, 19) == 0) ? pick_value() : obs;
         r = member_request(cur_obs,
                            member_near(cur_obs, member_mode_type'($urandom_range(0, 3))),
                            $urandom_range(0, 24) != 0, i == count - 1,
                            erh_pkg::RAND_W'($urandom));
         send_request(r);
      end
   endtask

   task automatic test_random_traffic();
      int sizes [7];
      int phase_end;
      sizes = '{1, 2, 5, erh_pkg::MAX_MEMBERS, $urandom_range(3, 20), 12,
                $urandom_range(1, erh_pkg::MAX_MEMBERS)};
      for (int p = 0; p < 7; p++) begin
         write_ensemble_size(erh_pkg::CNT_W'(sizes[p]));
         steady_flow = (p == 2);
         phase_end   = requests_sent + RANDOM_ITEMS / 7;
         while (requests_sent < phase_end) begin
            case ($urandom_range(0, 9))
               0:       send_request(op_request(erh_pkg::OP_READ,
                                     ($urandom_range(0, 9) == 0) ?
                                     erh_pkg::BIN_W'($urandom_range(erh_pkg::NBINS, 127)) :
                                     erh_pkg::BIN_W'($urandom_range(0, erh_pkg::NBINS - 1))));
               default: send_random_ensemble(sizes[p]);
            endcase
            if ($urandom_range(0, 199) == 0) send_request(op_request(erh_pkg::OP_CLEAR, '0));
            if ($urandom_range(0, 99) == 0) send_request(random_request());
         end
         // Halfway through, let everything drain before going on.
         if (p == 3) wait_idle();
      end
      steady_flow = 1'b0;
   endtask

   initial begin
      foreach (bin_counts[i]) bin_counts[i] = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_single_member();
      test_size_extremes();
      test_clear_keeps_counters();
      test_random_traffic();
      wait_idle();
      $display("Checked %0d responses from %0d requests, %0d of them formed ranks.",
               responses_checked, requests_sent, ranks_formed);
      $display("Ensemble sizes 0, 1, 64 and 127 plus random ones, with clears and reads.");
      if (error_count == 0 && pending_results.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
